/* rtl/nwt_pkg.sv */
// Shared token codes, sizes and helpers for the number-to-word token block.
`default_nettype none

package nwt_pkg;

	// Token word type and codes
	typedef logic [4:0] word_t;

	localparam word_t TOK_ZERO      = 5'd0;
	localparam word_t TOK_TEEN_BASE = 5'd10;
	localparam word_t TOK_TENS_BASE = 5'd18;
	localparam word_t TOK_HUNDRED   = 5'd28;

	// Sizes
	localparam int VALUE_BITS_DEF = 31;
	localparam int MAX_TOKENS     = 16;
	localparam int GROUP_DIGITS   = 12;	// billion, million, thousand, unit groups

	// Decimal digits needed to hold a binary number of the given width
	function automatic int bcd_digits(input int bits);
		return (bits * 301) / 1000 + 1;
	endfunction

endpackage

`default_nettype wire

/* rtl/nwt_bcd.sv */
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none

module nwt_bcd
	import nwt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int NDIG       = bcd_digits(VALUE_BITS_DEF)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic [VALUE_BITS-1:0] bin,
	output logic                       done,
	output logic [NDIG*4-1:0]          bcd
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [NDIG*4-1:0]     bcd_q;
	logic [NDIG*4-1:0]     adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	// Add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Control: bit counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift binary MSB into BCD
	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[NDIG*4-2:0], bin_q[VALUE_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

/* rtl/number_to_word_tokens.sv */
// Top level: spells a binary number as a run of English word tokens.
//
// A number is taken when start is high and busy is low; busy then stays high
// until the spelling is finished. The block first converts the number to
// decimal in a shift-and-add-3 unit, one bit per cycle, then walks the
// billion, million, thousand and unit groups with a small sequencer of up
// to five steps per group, giving at most one token per cycle. Each token
// beat is shown on word and last_word for exactly one cycle, marked by
// valid; the receiver cannot stall it, so it must take every beat as it
// comes. last_word is high on the final token, and at most 16 tokens are
// given.
`default_nettype none

module number_to_word_tokens
	import nwt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       valid,
	output logic [4:0]                 word,
	output logic                       last_word
);

	localparam int NDIG    = bcd_digits(VALUE_BITS);
	localparam int GRP_W   = GROUP_DIGITS * 4;
	localparam int TCNT_W  = $clog2(MAX_TOKENS);

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CONV  = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	// Steps within one group
	localparam logic [2:0] P_HDIG  = 3'd0;
	localparam logic [2:0] P_HWORD = 3'd1;
	localparam logic [2:0] P_TENS  = 3'd2;
	localparam logic [2:0] P_UNITS = 3'd3;
	localparam logic [2:0] P_SCALE = 3'd4;

	logic [1:0]        state_q;
	logic [1:0]        g_q;
	logic [2:0]        ph_q;
	logic [TCNT_W-1:0] cnt_q;
	word_t             pend_q;
	logic              pend_v_q;
	logic              valid_q;
	word_t             word_q;
	logic              last_q;

	logic              load;
	logic              bcd_done;
	logic [NDIG*4-1:0] bcd;
	logic [GRP_W-1:0]  bcd_all;
	logic [11:0]       grp;
	logic [3:0]        dh;
	logic [3:0]        dt;
	logic [3:0]        du;
	logic              grp_nz;
	logic              tok_v;
	word_t             tok;
	logic              grp_end;

	assign busy = (state_q != S_IDLE);
	assign load = start && !busy;

	nwt_bcd #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG)
	) u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.bin   (value),
		.done  (bcd_done),
		.bcd   (bcd)
	);

	// Current group's digits
	assign bcd_all = GRP_W'(bcd);
	assign grp     = bcd_all[g_q*12 +: 12];
	assign dh      = grp[11:8];
	assign dt      = grp[7:4];
	assign du      = grp[3:0];
	assign grp_nz  = (grp != 12'd0);

	// Token for the current step, if any
	always_comb begin
		tok_v = 1'b0;
		tok   = TOK_ZERO;
		unique case (ph_q)
			P_HDIG: begin
				tok_v = (dh != 4'd0);
				tok   = {1'b0, dh};
			end
			P_HWORD: begin
				tok_v = (dh != 4'd0);
				tok   = TOK_HUNDRED;
			end
			P_TENS: begin
				if (dt >= 4'd2) begin
					tok_v = 1'b1;
					tok   = TOK_TENS_BASE + {1'b0, dt};
				end else if (dt == 4'd1) begin
					tok_v = 1'b1;
					tok   = TOK_TEEN_BASE + {1'b0, du};
				end else begin
					tok_v = (du != 4'd0);
					tok   = {1'b0, du};
				end
			end
			P_UNITS: begin
				tok_v = (dt >= 4'd2) && (du != 4'd0);
				tok   = {1'b0, du};
			end
			P_SCALE: begin
				tok_v = (g_q != 2'd0);
				tok   = TOK_HUNDRED + {3'b000, g_q};
			end
			default: begin
				tok_v = 1'b0;
				tok   = TOK_ZERO;
			end
		endcase
		if (!grp_nz) begin
			tok_v = 1'b0;
		end
	end

	assign grp_end = (ph_q == P_SCALE) || !grp_nz;

	// Sequencer: one token held back so the last one can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			g_q      <= '0;
			ph_q     <= P_HDIG;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (bcd_done) begin
						if (bcd == '0) begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							g_q      <= 2'd3;
							ph_q     <= P_HDIG;
							cnt_q    <= '0;
							pend_v_q <= 1'b0;
							state_q  <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (grp_end) begin
						ph_q <= P_HDIG;
						if (g_q == 2'd0) begin
							state_q <= S_FLUSH;
						end else begin
							g_q <= g_q - 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
					if (tok_v) begin
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							valid_q <= 1'b1;
							cnt_q   <= cnt_q + 1'b1;
							if (cnt_q == TCNT_W'(MAX_TOKENS - 1)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_FLUSH: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Token payload and last flag
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CONV: begin
				word_q <= TOK_ZERO;
				last_q <= 1'b1;
			end
			S_EMIT: begin
				if (tok_v) begin
					pend_q <= tok;
					word_q <= pend_q;
					last_q <= (cnt_q == TCNT_W'(MAX_TOKENS - 1));
				end
			end
			S_FLUSH: begin
				word_q <= pend_q;
				last_q <= 1'b1;
			end
			default: begin
				word_q <= word_q;
				last_q <= last_q;
			end
		endcase
	end

	assign valid     = valid_q;
	assign word      = word_q;
	assign last_word = last_q;

endmodule

`default_nettype wire

/* verif/number_to_word_tokens_checker.sv */
// Checker for the number-to-word token block: predicts each spelling and compares token beats.
`default_nettype none

module number_to_word_tokens_checker
	import nwt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire logic [VALUE_BITS_DEF-1:0] value,
	input  wire logic                      valid,
	input  wire logic [4:0]                word,
	input  wire logic                      last_word,
	output int                             errors,
	output int                             pending
);

	// Scale words
	localparam word_t TOK_THOUSAND = 5'd29;
	localparam word_t TOK_MILLION  = 5'd30;
	localparam word_t TOK_BILLION  = 5'd31;

	typedef struct packed {
		word_t word;
		logic  last;
	} token_t;

	token_t due_tokens[$];	// tokens still owed by the block, oldest first
	word_t  spelling[$];	// scratch: spelling of the number being predicted

	// Hundreds, then tens/teens/units of one group of 1..999
	task automatic spell_group(input int unsigned grp);
		int unsigned hund;
		int unsigned rest;
		hund = grp / 100;
		rest = grp % 100;
		if (hund != 0) begin
			spelling.push_back(word_t'(hund));
			spelling.push_back(TOK_HUNDRED);
		end
		if (rest >= 20) begin
			spelling.push_back(TOK_TENS_BASE + word_t'(rest / 10));
			if (rest % 10 != 0)
				spelling.push_back(word_t'(rest % 10));
		end else if (rest != 0) begin
			spelling.push_back(word_t'(rest));
		end
	endtask

	// Full spelling of one number, capped at the token limit
	task automatic predict_spelling(input logic [VALUE_BITS_DEF-1:0] num);
		longint unsigned v;
		int unsigned     grp_b;
		int unsigned     grp_m;
		int unsigned     grp_t;
		int unsigned     grp_u;
		int              n;
		v = num;
		spelling.delete();
		if (v == 0) begin
			spelling.push_back(TOK_ZERO);
		end else begin
			grp_b = int'((v / 64'd1000000000) % 1000);
			grp_m = int'((v / 64'd1000000) % 1000);
			grp_t = int'((v / 64'd1000) % 1000);
			grp_u = int'(v % 1000);
			if (grp_b != 0) begin
				spell_group(grp_b);
				spelling.push_back(TOK_BILLION);
			end
			if (grp_m != 0) begin
				spell_group(grp_m);
				spelling.push_back(TOK_MILLION);
			end
			if (grp_t != 0) begin
				spell_group(grp_t);
				spelling.push_back(TOK_THOUSAND);
			end
			if (grp_u != 0)
				spell_group(grp_u);
		end
		n = (spelling.size() > MAX_TOKENS) ? MAX_TOKENS : spelling.size();
		for (int k = 0; k < n; k++)
			due_tokens.push_back('{word: spelling[k], last: (k == n - 1)});
	endtask

	// Watch both channels: compare token beats, then queue new predictions
	always @(posedge clk or negedge arst_n) begin : watch
		int     fails;
		token_t exp_tok;
		fails = 0;
		if (!arst_n) begin
			due_tokens.delete();
		end else begin
			if (valid) begin
				if (due_tokens.size() == 0) begin
					$display("%0t: unexpected token: expected none, actual word %0d last %0b",
						$time, word, last_word);
					fails++;
				end else begin
					exp_tok = due_tokens.pop_front();
					if (word !== exp_tok.word || last_word !== exp_tok.last) begin
						$display({"%0t: token mismatch: expected word %0d last %0b, ",
							"actual word %0d last %0b"},
							$time, exp_tok.word, exp_tok.last, word, last_word);
						fails++;
					end
				end
			end
			if (start && !busy)
				predict_spelling(value);
		end
		errors  <= errors + fails;
		pending <= due_tokens.size();
	end

endmodule

`default_nettype wire

/* verif/tb_number_to_word_tokens.sv */
// Testbench top for the number-to-word token block: stimulus, reset and verdict.
`default_nettype none

module tb_number_to_word_tokens;
	import nwt_pkg::*;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      start  = 1'b0;
	logic [VALUE_BITS_DEF-1:0] value  = '0;
	logic                      busy;
	logic                      valid;
	logic [4:0]                word;
	logic                      last_word;
	int                        errors;
	int                        pending;

	number_to_word_tokens u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.valid     (valid),
		.word      (word),
		.last_word (last_word)
	);

	number_to_word_tokens_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.valid     (valid),
		.word      (word),
		.last_word (last_word),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAIL number_to_word_tokens");
		$finish;
	end

	// Offer one number and hold it until the block takes the beat; idle cycles at random when may_idle is set
	task automatic send_number(input logic [VALUE_BITS_DEF-1:0] num, input bit may_idle);
		bit taken;
		taken = 1'b0;
		value <= num;
		while (!taken) begin
			if (may_idle && $urandom_range(99) < 24)
				start <= 1'b0;
			else
				start <= 1'b1;
			@(posedge clk);
			taken = start && !busy;
		end
	endtask

	// Mix of sizes, with group-structured numbers to hit zero groups and teens
	function automatic logic [VALUE_BITS_DEF-1:0] random_number();
		longint unsigned v;
		longint unsigned grp;
		v = 0;
		case ($urandom_range(5))
			0: v = $urandom_range(999);
			1: v = $urandom_range(999999);
			2: v = $urandom_range(999999999);
			3: v = $urandom_range(32'h7fff_ffff);
			4: begin
				for (int i = 0; i < 4; i++) begin
					grp = ($urandom_range(2) == 0) ? 0 : $urandom_range(999);
					if (i == 0)
						grp = grp % 3;
					v = v * 1000 + grp;
				end
				if (v > 64'h7fff_ffff)
					v = v - 64'd1000000000;
			end
			default: v = $urandom_range(20);
		endcase
		return v[VALUE_BITS_DEF-1:0];
	endfunction

	initial begin
		int unsigned directed[$] = {
			0, 1, 7, 10, 13, 19, 20, 21, 45, 99, 100, 101, 115, 999, 1000, 1001,
			10000, 99999, 1000000, 12345678, 900080070, 1000000000, 2000000000,
			1777777777, 2147483647
		};
		int waited;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_number(directed[i][VALUE_BITS_DEF-1:0], 1'b0);

		for (int i = 0; i < 95; i++) begin
			// let the block drain completely once
			if (i == 30) begin
				start <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			send_number(random_number(), !(i >= 50 && i < 85));
		end
		start <= 1'b0;

		// drain, then wait quietly for stray beats
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 5000);
		repeat (60) @(posedge clk);

		if (pending != 0)
			$display("%0t: tokens outstanding: expected 0, actual %0d", $time, pending);
		if (errors == 0 && pending == 0)
			$display("PASS number_to_word_tokens");
		else
			$display("FAIL number_to_word_tokens");
		$finish;
	end

endmodule

`default_nettype wire

/* number_to_word_tokens.f */
rtl/nwt_pkg.sv
rtl/nwt_bcd.sv
rtl/number_to_word_tokens.sv
verif/number_to_word_tokens_checker.sv
verif/tb_number_to_word_tokens.sv
